@@ hw/rtl/tli_pkg.sv @@
`timescale 1ns / 1ps

package tli_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int ACT_W  = 2;
  localparam int ANG_W  = 16;
  localparam int VAL_W  = 16;
  localparam int ST_W   = 3;
  localparam int DIFF_W = 17;   // angle / coefficient differences
  localparam int PROD_W = 34;   // signed product of two differences
  localparam int QUO_W  = 32;   // magnitude of the product fits here
  localparam int DEN_W  = 16;   // segment width, always 2..65535

  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  localparam logic [ST_W-1:0] ST_EXACT  = 3'd0;
  localparam logic [ST_W-1:0] ST_INTERP = 3'd1;
  localparam logic [ST_W-1:0] ST_RANGE  = 3'd2;
  localparam logic [ST_W-1:0] ST_FEW    = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL   = 3'd4;
  localparam logic [ST_W-1:0] ST_OK     = 3'd5;

  typedef enum logic [1:0] {
    RES_HOLD,
    RES_CODE,
    RES_EXACT,
    RES_INTERP
  } res_op_t;

  typedef struct packed {
    logic            capture;
    logic            clear;
    logic            append;
    logic            scan_start;
    logic            adv;
    logic            mul_load;
    logic            div_start;
    res_op_t         res_op;
    logic [ST_W-1:0] res_code;
    logic            out_load;
  } tli_cmd_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             few;
    logic             full;
    logic             eq;
    logic             ge;
    logic             first;
    logic             last;
    logic             div_done;
  } tli_sts_t;

endpackage

@@ hw/rtl/tli_if.sv @@
`timescale 1ns / 1ps

interface tli_req_if import tli_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic signed [ANG_W-1:0] angle;
  logic signed [VAL_W-1:0] coefficient;

  modport source (output valid, action, angle, coefficient, input ready);
  modport sink   (input valid, action, angle, coefficient, output ready);
endinterface

interface tli_rsp_if import tli_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] result_value;
  logic [ST_W-1:0]         status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

@@ hw/rtl/tli_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module tli_div import tli_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [QUO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(QUO_W);

  logic [DEN_W-1:0] rem_r;
  logic [QUO_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             take;

  assign trial = {rem_r, quo_r[QUO_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUO_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], take};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r && !done_r)
    else $error("divider not busy after start");

endmodule

@@ hw/rtl/tli_dp.sv @@
`timescale 1ns / 1ps

module tli_dp import tli_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [ACT_W-1:0]        in_action,
  input  logic signed [ANG_W-1:0] in_angle,
  input  logic signed [VAL_W-1:0] in_coefficient,
  input  tli_cmd_t                cmd,
  output tli_sts_t                sts,
  output logic signed [VAL_W-1:0] out_result_value,
  output logic [ST_W-1:0]         out_status
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = -PROD_W'(32768);

  logic signed [ANG_W-1:0] angle_mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] value_mem [TABLE_DEPTH];

  logic [ACT_W-1:0]         act_r;
  logic signed [ANG_W-1:0]  q_r;
  logic signed [VAL_W-1:0]  coef_r;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            rd_idx_r;
  logic [CW-1:0]            dat_idx_r;
  logic signed [ANG_W-1:0]  ang_q_r;
  logic signed [VAL_W-1:0]  val_q_r;
  logic signed [ANG_W-1:0]  prev_ang_r;
  logic signed [VAL_W-1:0]  prev_val_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [DEN_W-1:0]         den_r;
  logic signed [VAL_W-1:0]  fa_r;
  logic signed [VAL_W-1:0]  res_val_r;
  logic [ST_W-1:0]          res_st_r;
  logic signed [VAL_W-1:0]  out_val_r;
  logic [ST_W-1:0]          out_st_r;

  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic signed [DIFF_W-1:0] span_d;
  logic signed [DIFF_W-1:0] val_d;
  logic signed [DIFF_W-1:0] den_d;
  logic signed [PROD_W-1:0] prod_abs;
  logic                     div_done;
  logic [QUO_W-1:0]         quo;
  logic signed [PROD_W-1:0] qmag;
  logic signed [PROD_W-1:0] qsig;
  logic signed [PROD_W-1:0] sum;
  logic signed [VAL_W-1:0]  sat_val;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= in_action;
      q_r    <= in_angle;
      coef_r <= in_coefficient;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (cmd.append) begin
      count_r <= count_r + CW'(1);
    end
  end

  // Scan pipeline: address issued the cycle before the compare.
  assign rd_en   = cmd.scan_start | cmd.adv;
  assign rd_addr = cmd.scan_start ? '0 : rd_idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      angle_mem[count_r[AW-1:0]] <= q_r;
      value_mem[count_r[AW-1:0]] <= coef_r;
    end
    if (rd_en) begin
      ang_q_r <= angle_mem[rd_addr];
      val_q_r <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      rd_idx_r  <= CW'(1);
      dat_idx_r <= '0;
    end else if (cmd.adv) begin
      rd_idx_r   <= rd_idx_r + CW'(1);
      dat_idx_r  <= rd_idx_r;
      prev_ang_r <= ang_q_r;
      prev_val_r <= val_q_r;
    end
  end

  // Segment math: (q - a) * (fc - fa), then divide by (c - a), add fa and saturate.
  assign span_d = DIFF_W'(q_r) - DIFF_W'(prev_ang_r);
  assign val_d  = DIFF_W'(val_q_r) - DIFF_W'(prev_val_r);
  assign den_d  = DIFF_W'(ang_q_r) - DIFF_W'(prev_ang_r);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r <= span_d * val_d;
      den_r  <= den_d[DEN_W-1:0];
      fa_r   <= prev_val_r;
    end
  end

  assign prod_abs = prod_r[PROD_W-1] ? -prod_r : prod_r;

  tli_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_abs[QUO_W-1:0]),
    .divisor  (den_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign qmag = {{(PROD_W-QUO_W){1'b0}}, quo};
  assign qsig = prod_r[PROD_W-1] ? -qmag : qmag;
  assign sum  = qsig + PROD_W'(fa_r);

  always_comb begin
    priority if (sum > SAT_HI) begin
      sat_val = 16'sh7FFF;
    end else if (sum < SAT_LO) begin
      sat_val = 16'sh8000;
    end else begin
      sat_val = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.res_op)
      RES_HOLD: begin
      end
      RES_CODE: begin
        res_val_r <= '0;
        res_st_r  <= cmd.res_code;
      end
      RES_EXACT: begin
        res_val_r <= val_q_r;
        res_st_r  <= ST_EXACT;
      end
      RES_INTERP: begin
        res_val_r <= sat_val;
        res_st_r  <= ST_INTERP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_val_r <= res_val_r;
      out_st_r  <= res_st_r;
    end
  end

  assign sts.action   = act_r;
  assign sts.few      = (count_r < CW'(2));
  assign sts.full     = (count_r == CW'(TABLE_DEPTH));
  assign sts.eq       = (ang_q_r == q_r);
  assign sts.ge       = (ang_q_r >= q_r);
  assign sts.first    = (dat_idx_r == '0);
  assign sts.last     = (dat_idx_r == count_r - CW'(1));
  assign sts.div_done = div_done;

  assign out_result_value = out_val_r;
  assign out_status       = out_st_r;

  a_no_adv_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.adv |-> !sts.last && !sts.ge)
    else $error("scan advanced past its stop point");

  a_no_append_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.append |-> !sts.full)
    else $error("append into full table");

endmodule

@@ hw/rtl/tli_ctrl.sv @@
`timescale 1ns / 1ps

module tli_ctrl import tli_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output tli_cmd_t cmd,
  input  tli_sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DSTART,
    S_DWAIT,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.res_op   = RES_HOLD;
    cmd.res_code = ST_OK;
    state_nxt    = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        cmd.res_op = RES_CODE;
        unique case (sts.action)
          ACT_CLEAR: begin
            cmd.clear = 1'b1;
          end
          ACT_APPEND: begin
            if (sts.full) begin
              cmd.res_code = ST_FULL;
            end else begin
              cmd.append = 1'b1;
            end
          end
          ACT_QUERY: begin
            if (sts.few) begin
              cmd.res_code = ST_FEW;
            end else begin
              cmd.res_op     = RES_HOLD;
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        priority if (sts.eq) begin
          cmd.res_op = RES_EXACT;
          state_nxt  = S_DONE;
        end else if (sts.ge && sts.first) begin
          cmd.res_op   = RES_CODE;
          cmd.res_code = ST_RANGE;
          state_nxt    = S_DONE;
        end else if (sts.ge) begin
          cmd.mul_load = 1'b1;
          state_nxt    = S_DSTART;
        end else if (sts.last) begin
          cmd.res_op   = RES_CODE;
          cmd.res_code = ST_RANGE;
          state_nxt    = S_DONE;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      S_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DWAIT;
      end
      S_DWAIT: begin
        if (sts.div_done) begin
          cmd.res_op = RES_INTERP;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r || out_ready)
    else $error("pending result overwritten");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DWAIT)
    else $error("divider finished outside its wait state");

endmodule

@@ hw/rtl/table_linear_interpolator_top.sv @@
`timescale 1ns / 1ps
// Clear, append and unused actions go from accept through decode and done back to idle.
// Query scans the table linearly (one entry a cycle) and stops on an exact hit,
// out of range, or on the segment it interpolates through the 32-step divider;
// a result not yet taken by the sink holds the done state before the next accept.
// Reset (synchronous, rst_n low) empties the table and drops any pending result.

module table_linear_interpolator_top import tli_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input logic      clk,
  input logic      rst_n,
  tli_req_if.sink  in_req,
  tli_rsp_if.source out_rsp
);

  // Controller sequences each request; the datapath holds the table,
  // the scan registers, the multiplier stage and the divider.
  tli_cmd_t cmd;
  tli_sts_t sts;

  tli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Table is a plain memory: entries above the fill count are never read,
  // so it needs no clearing pass.
  tli_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_action        (in_req.action),
    .in_angle         (in_req.angle),
    .in_coefficient   (in_req.coefficient),
    .cmd              (cmd),
    .sts              (sts),
    .out_result_value (out_rsp.result_value),
    .out_status       (out_rsp.status)
  );

endmodule
